// ===== sv/rvsd_pkg.sv =====
// shared types and constants for the repeated value streak detector
// used by rvsd_front, rvsd_queue, rvsd_back and the top level; no dependencies
`default_nettype none

package rvsd_pkg;

  localparam int INDEX_BITS  = 20;
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 20;
  localparam int TIME_BITS   = 32;
  localparam int DAY_BITS    = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 20;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_BITS-1:0] MIN_RUN_POINTS = COUNT_BITS'(10);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX      = {COUNT_BITS{1'b1}};

  // input tdata: sample then time_hours, padded to whole bytes
  localparam int IN_DATA_BITS  = ((SAMPLE_BITS + TIME_BITS + 7) / 8) * 8;
  // output tdata: start index, count, span
  localparam int OUT_RAW_BITS  = INDEX_BITS + COUNT_BITS + TIME_BITS;
  localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RUN_LENGTH_LIMIT = 3'd0,
    REG_RUN_DAY_LIMIT    = 3'd1,
    REG_WIND_MODE        = 3'd2,
    REG_WIND_MINIMUM     = 3'd3,
    REG_DIRECTION_MODE   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]   run_length_limit;
    logic [DAY_BITS-1:0]     run_day_limit;
    logic                    wind_mode;
    logic signed [15:0]      wind_minimum;
    logic                    direction_mode;
  } cfg_t;

  localparam logic [COUNT_BITS-1:0] RST_RUN_LENGTH_LIMIT = COUNT_BITS'(40);
  localparam logic [DAY_BITS-1:0]   RST_RUN_DAY_LIMIT    = DAY_BITS'(14);
  localparam logic signed [15:0]    RST_WIND_MINIMUM     = 16'sd5;

  // one finished run waiting for reporting
  typedef struct packed {
    logic [INDEX_BITS-1:0] start_pos;
    logic [COUNT_BITS-1:0] points;
    logic [TIME_BITS-1:0]  start_time;
    logic [TIME_BITS-1:0]  last_time;
  } run_rec_t;

endpackage

`default_nettype wire

// ===== sv/rvsd_front.sv =====
// front end: accepts samples, tracks the open run and pushes finished runs
// depends on rvsd_pkg
`default_nettype none

module rvsd_front (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire rvsd_pkg::cfg_t                        cfg,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [rvsd_pkg::SAMPLE_BITS-1:0] sample,
  input  wire logic                                  missing,
  input  wire logic [rvsd_pkg::TIME_BITS-1:0]        time_hours,
  input  wire logic                                  q_full,
  output logic                                       q_push,
  output rvsd_pkg::run_rec_t                         q_data
);

  logic                                  have_value;
  logic signed [rvsd_pkg::SAMPLE_BITS-1:0] current_value;
  logic [rvsd_pkg::INDEX_BITS-1:0]       run_start_position;
  logic [rvsd_pkg::TIME_BITS-1:0]        run_start_time;
  logic [rvsd_pkg::TIME_BITS-1:0]        run_last_time;
  logic [rvsd_pkg::COUNT_BITS-1:0]       run_points;
  logic [rvsd_pkg::INDEX_BITS-1:0]       position_counter;

  logic accept;
  logic skip;
  logic new_run;
  logic report;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // a zero in direction mode is a calm
  assign skip    = missing || (cfg.direction_mode && (sample == '0));
  assign new_run = !skip && (!have_value || (sample != current_value));
  assign report  = new_run && have_value && (run_points >= rvsd_pkg::MIN_RUN_POINTS) &&
                   (!cfg.wind_mode || (current_value > cfg.wind_minimum));

  assign q_push            = accept && report;
  assign q_data.start_pos  = run_start_position;
  assign q_data.points     = run_points;
  assign q_data.start_time = run_start_time;
  assign q_data.last_time  = run_last_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_value         <= 1'b0;
      current_value      <= '0;
      run_start_position <= '0;
      run_start_time     <= '0;
      run_last_time      <= '0;
      run_points         <= '0;
      position_counter   <= '0;
    end else if (accept) begin
      position_counter <= position_counter + 1'b1;
      if (new_run) begin
        have_value         <= 1'b1;
        current_value      <= sample;
        run_start_position <= position_counter;
        run_start_time     <= time_hours;
        run_last_time      <= time_hours;
        run_points         <= rvsd_pkg::COUNT_BITS'(1);
      end else if (!skip) begin
        if (run_points != rvsd_pkg::COUNT_MAX) begin
          run_points <= run_points + 1'b1;
        end
        run_last_time <= time_hours;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/rvsd_queue.sv =====
// short queue of finished runs between front and back
// depends on rvsd_pkg
`default_nettype none

module rvsd_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire rvsd_pkg::run_rec_t  push_data,
  output logic                     full,
  input  wire logic                pop,
  output logic                     not_empty,
  output rvsd_pkg::run_rec_t       pop_data
);

  rvsd_pkg::run_rec_t                slots [rvsd_pkg::QUEUE_DEPTH];
  logic [rvsd_pkg::QPTR_BITS-1:0]    wr_ptr;
  logic [rvsd_pkg::QPTR_BITS-1:0]    rd_ptr;
  logic [rvsd_pkg::QCNT_BITS-1:0]    count;

  localparam logic [rvsd_pkg::QPTR_BITS-1:0] LAST_SLOT =
    rvsd_pkg::QPTR_BITS'(rvsd_pkg::QUEUE_DEPTH - 1);
  localparam logic [rvsd_pkg::QCNT_BITS-1:0] DEPTH_CNT =
    rvsd_pkg::QCNT_BITS'(rvsd_pkg::QUEUE_DEPTH);

  assign full      = (count == DEPTH_CNT);
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/rvsd_back.sv =====
// back end: works out span and flag of a finished run and holds the result
// depends on rvsd_pkg
`default_nettype none

module rvsd_back (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire rvsd_pkg::cfg_t                     cfg,
  input  wire logic                               q_not_empty,
  input  wire rvsd_pkg::run_rec_t                 q_data,
  output logic                                    q_pop,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [rvsd_pkg::INDEX_BITS-1:0]         run_start_index,
  output logic [rvsd_pkg::COUNT_BITS-1:0]         run_count,
  output logic [rvsd_pkg::TIME_BITS-1:0]          run_span_hours,
  output logic                                    flag_run
);

  logic [rvsd_pkg::TIME_BITS-1:0] span;
  logic [rvsd_pkg::DAY_BITS+4:0]  day_hours;
  logic                           flag;

  // days times 24 as 16x plus 8x
  assign day_hours = {1'b0, cfg.run_day_limit, 4'b0000} +
                     {2'b00, cfg.run_day_limit, 3'b000};
  assign span = q_data.last_time - q_data.start_time;
  assign flag = (q_data.points >= cfg.run_length_limit) ||
                (span >= rvsd_pkg::TIME_BITS'(day_hours));

  assign q_pop = q_not_empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      run_start_index <= q_data.start_pos;
      run_count       <= q_data.points;
      run_span_hours  <= span;
      flag_run        <= flag;
    end
  end

endmodule

`default_nettype wire

// ===== sv/repeated_value_streak_detector_top.sv =====
// top level of the repeated value streak detector: stream ports, config registers
// depends on rvsd_pkg, rvsd_front, rvsd_queue, rvsd_back
`default_nettype none

// Follows runs of identical non-missing samples and reports each finished run
// of ten or more points (in wind mode, only those above the wind minimum) with
// start position, length, span in hours and flag once a different value ends
// it. One sample is taken per clock cycle while s_axis_tready is high; ended
// runs wait in a two-entry queue before the result stage until it is free, and
// s_axis_tready drops only while that queue is full because results are not
// being taken. Configuration writes take effect at the next edge and should
// be made while no results are pending.
module repeated_value_streak_detector_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [rvsd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [rvsd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // sample [15:0], time_hours [47:16]
  input  wire logic [rvsd_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
  // missing [0]
  input  wire logic                                  s_axis_tuser,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // run_start_index [19:0], run_count [39:20], run_span_hours [71:40]
  output logic [rvsd_pkg::OUT_DATA_BITS-1:0]         m_axis_tdata,
  // flag_run [0]
  output logic                                       m_axis_tuser
);

  rvsd_pkg::cfg_t     cfg;
  rvsd_pkg::run_rec_t push_data;
  rvsd_pkg::run_rec_t pop_data;
  logic               q_full;
  logic               q_push;
  logic               q_pop;
  logic               q_not_empty;

  logic [rvsd_pkg::INDEX_BITS-1:0] run_start_index;
  logic [rvsd_pkg::COUNT_BITS-1:0] run_count;
  logic [rvsd_pkg::TIME_BITS-1:0]  run_span_hours;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.run_length_limit <= rvsd_pkg::RST_RUN_LENGTH_LIMIT;
      cfg.run_day_limit    <= rvsd_pkg::RST_RUN_DAY_LIMIT;
      cfg.wind_mode        <= 1'b0;
      cfg.wind_minimum     <= rvsd_pkg::RST_WIND_MINIMUM;
      cfg.direction_mode   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        rvsd_pkg::REG_RUN_LENGTH_LIMIT:
          cfg.run_length_limit <= cfg_data[rvsd_pkg::COUNT_BITS-1:0];
        rvsd_pkg::REG_RUN_DAY_LIMIT:
          cfg.run_day_limit <= cfg_data[rvsd_pkg::DAY_BITS-1:0];
        rvsd_pkg::REG_WIND_MODE:
          cfg.wind_mode <= cfg_data[0];
        rvsd_pkg::REG_WIND_MINIMUM:
          cfg.wind_minimum <= signed'(cfg_data[15:0]);
        rvsd_pkg::REG_DIRECTION_MODE:
          cfg.direction_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rvsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .sample     (signed'(s_axis_tdata[rvsd_pkg::SAMPLE_BITS-1:0])),
    .missing    (s_axis_tuser),
    .time_hours (s_axis_tdata[rvsd_pkg::SAMPLE_BITS +: rvsd_pkg::TIME_BITS]),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (push_data)
  );

  rvsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_data)
  );

  rvsd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_not_empty     (q_not_empty),
    .q_data          (pop_data),
    .q_pop           (q_pop),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .run_start_index (run_start_index),
    .run_count       (run_count),
    .run_span_hours  (run_span_hours),
    .flag_run        (m_axis_tuser)
  );

  assign m_axis_tdata = rvsd_pkg::OUT_DATA_BITS'({run_span_hours, run_count, run_start_index});

endmodule

`default_nettype wire

// ===== sim/tb_repeated_value_streak_detector_top.sv =====
// self-checking bench for repeated_value_streak_detector_top: drives sample streams
// and register settings, predicts streak reports in a scoreboard class
// depends on rvsd_pkg and the repeated_value_streak_detector_top rtl
`default_nettype none

module tb_repeated_value_streak_detector_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rvsd_pkg::*;

  localparam logic [TIME_BITS-1:0] HOURS_PER_DAY = 32'd24;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 10;
  localparam longint LIMIT_NS = 64'd40_000_000;

  typedef struct packed {
    logic [INDEX_BITS-1:0] start;
    logic [COUNT_BITS-1:0] count;
    logic [TIME_BITS-1:0]  span;
    logic                  flag;
  } streak_rpt_t;

  class streak_scoreboard;
    logic [COUNT_BITS-1:0]  len_limit;
    logic [DAY_BITS-1:0]    day_limit;
    logic                   wind_en;
    logic signed [15:0]     wind_min;
    logic                   dir_en;

    bit                     have_val;
    logic signed [15:0]     cur_val;
    logic [INDEX_BITS-1:0]  start_pos;
    logic [INDEX_BITS-1:0]  pos_cnt;
    logic [COUNT_BITS-1:0]  points;
    logic [TIME_BITS-1:0]   t_start;
    logic [TIME_BITS-1:0]   t_last;

    streak_rpt_t expected_runs[$];
    int errors;
    int reported;
    int checked;

    function new();
      len_limit = RST_RUN_LENGTH_LIMIT;
      day_limit = RST_RUN_DAY_LIMIT;
      wind_en   = 1'b0;
      wind_min  = RST_WIND_MINIMUM;
      dir_en    = 1'b0;
      have_val  = 1'b0;
      cur_val   = '0;
      start_pos = '0;
      pos_cnt   = '0;
      points    = '0;
      t_start   = '0;
      t_last    = '0;
      errors    = 0;
      reported  = 0;
      checked   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
      case (idx)
        REG_RUN_LENGTH_LIMIT: len_limit = d[COUNT_BITS-1:0];
        REG_RUN_DAY_LIMIT:    day_limit = d[DAY_BITS-1:0];
        REG_WIND_MODE:        wind_en   = d[0];
        REG_WIND_MINIMUM:     wind_min  = d[15:0];
        REG_DIRECTION_MODE:   dir_en    = d[0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [15:0] smp, logic miss, logic [TIME_BITS-1:0] hrs);
      logic skip;
      logic [TIME_BITS-1:0] span;
      streak_rpt_t rpt;
      // a zero in direction mode is a calm and counts as a gap
      skip = miss || (dir_en && smp == 16'sd0);
      if (!skip) begin
        if (!have_val || smp != cur_val) begin
          if (have_val && points >= MIN_RUN_POINTS && (!wind_en || cur_val > wind_min)) begin
            span = t_last - t_start;
            rpt.start = start_pos;
            rpt.count = points;
            rpt.span  = span;
            rpt.flag  = (points >= len_limit) ||
                        (span >= 32'(day_limit) * HOURS_PER_DAY);
            expected_runs.insert(expected_runs.size(), rpt);
            reported++;
          end
          have_val  = 1'b1;
          cur_val   = smp;
          start_pos = pos_cnt;
          t_start   = hrs;
          t_last    = hrs;
          points    = COUNT_BITS'(1);
        end else begin
          if (points != COUNT_MAX) points++;
          t_last = hrs;
        end
      end
      pos_cnt++;
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t mismatch %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_run(logic [OUT_DATA_BITS-1:0] data, logic flag);
      streak_rpt_t want;
      if (expected_runs.size() == 0) begin
        errors++;
        $display("%0t unexpected streak report expected none actual %h/%b", $time, data, flag);
        return;
      end
      want = expected_runs.pop_front();
      cmp("run_start_index", 32'(want.start), 32'(data[INDEX_BITS-1:0]));
      cmp("run_count", 32'(want.count), 32'(data[INDEX_BITS +: COUNT_BITS]));
      cmp("run_span_hours", want.span, data[INDEX_BITS+COUNT_BITS +: TIME_BITS]);
      cmp("flag_run", 32'(want.flag), 32'(flag));
      checked++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_BITS-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic m_axis_tuser;

  streak_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int settings = 0;
  logic [TIME_BITS-1:0] t_now = '0;
  bit hold_toggle = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  repeated_value_streak_detector_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // accepted sample requests feed the predictor
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready)
      sb.note_sample(s_axis_tdata[SAMPLE_BITS-1:0], s_axis_tuser,
                     s_axis_tdata[SAMPLE_BITS +: TIME_BITS]);
  end

  // result side: check, then pick next ready (long hold-off on request)
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_run(m_axis_tdata, m_axis_tuser);
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send_item(input logic signed [15:0] smp, input logic miss,
                           input logic [TIME_BITS-1:0] hrs);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_BITS'({hrs, smp});
    s_axis_tuser  <= miss;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_runs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task automatic set_config(input logic [CFG_DATA_BITS-1:0] len_d, day_d, wind_d,
                            min_d, dir_d);
    cfg_write(REG_RUN_LENGTH_LIMIT, len_d);
    cfg_write(REG_RUN_DAY_LIMIT, day_d);
    cfg_write(REG_WIND_MODE, wind_d);
    cfg_write(REG_WIND_MINIMUM, min_d);
    cfg_write(REG_DIRECTION_MODE, dir_d);
    // index past the register list must be ignored
    cfg_write(REG_DIRECTION_MODE + CFG_IDX_BITS'($urandom_range(1, 3)),
              CFG_DATA_BITS'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  task automatic step_time();
    int r;
    r = $urandom_range(0, 199);
    if (r < 2)      t_now -= $urandom_range(1, 100);
    else if (r < 6) t_now += $urandom_range(50, 700);
    else            t_now += $urandom_range(0, 3);
  endtask

  // mostly streaks of one value with gaps and calms, some noise bursts
  task automatic random_phase(input int n_items, input int min_reports, input bit press);
    int first;
    int len;
    int i;
    int r;
    bit pressed;
    logic signed [15:0] val;
    first = items_sent;
    pressed = 1'b0;
    while (items_sent - first < n_items || sb.reported < min_reports) begin
      if (press && !pressed && items_sent - first >= 40) begin
        hold_toggle <= ~hold_toggle;
        pressed = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, 4);
        for (i = 0; i < len; i++)
          send_item(16'($urandom), 1'($urandom), TIME_BITS'($urandom));
      end else begin
        case ($urandom_range(0, 9))
          0:       val = 16'sd0;
          1:       val = -16'sd32768;
          2:       val = 16'sd32767;
          3, 4, 5, 6: val = 16'($urandom_range(0, 50) - 20);
          default: val = 16'($urandom);
        endcase
        r = $urandom_range(0, 9);
        if (r == 0)      len = $urandom_range(1, 9);
        else if (r == 1) len = $urandom_range(31, 70);
        else             len = $urandom_range(10, 30);
        i = 0;
        while (i < len) begin
          step_time();
          r = $urandom_range(0, 99);
          if (r < 7) begin
            send_item(16'($urandom), 1'b1, t_now);
          end else if (r < 11 && sb.dir_en) begin
            send_item(16'sd0, 1'b0, t_now);
          end else begin
            send_item(val, 1'b0, t_now);
            i++;
          end
        end
      end
    end
  endtask

  initial begin
    int i;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: leading gap, zero run with a gap, backwards time run
    send_item(16'sd32767, 1'b1, 32'd0);
    for (i = 0; i < 10; i++) begin
      if (i == 5) send_item(-16'sd32768, 1'b1, 32'hFFFF_FFFF);
      send_item(16'sd0, 1'b0, 32'd100 + 32'(i));
    end
    for (i = 0; i < 10; i++)
      send_item(-16'sd32768, 1'b0, 32'd1000 - 32'(i));
    send_item(16'sd32767, 1'b0, 32'd2000);
    wait_idle();

    send_idle_pct = 0;  recv_stall_pct = 0;
    set_config(20'd40, 20'd14, 20'd0, 20'd5, 20'd0);
    t_now = $urandom;
    random_phase(180, 0, 1'b0);
    wait_idle();

    send_idle_pct = 64; recv_stall_pct = 0;
    set_config(20'd0, 20'd255, 20'd1, 20'h08000, 20'd1);
    t_now = 32'hFFFF_FF00;
    random_phase(200, 0, 1'b0);
    wait_idle();

    send_idle_pct = 0;  recv_stall_pct = 64;
    set_config(20'hFFFFF, 20'd1, 20'd1, 20'h07FFF, 20'd0);
    t_now = $urandom;
    random_phase(60, 0, 1'b0);
    wait_idle();

    send_idle_pct = 10; recv_stall_pct = 10;
    set_config(20'd25, 20'hFFF02, 20'h00003, 20'hF000C, 20'h00005);
    t_now = $urandom;
    random_phase(200, 0, 1'b0);
    wait_idle();

    send_idle_pct = 0;  recv_stall_pct = 64;
    set_config(CFG_DATA_BITS'($urandom_range(1, 60)), CFG_DATA_BITS'($urandom_range(1, 20)),
               CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom_range(0, 40) - 10),
               CFG_DATA_BITS'($urandom));
    t_now = $urandom;
    random_phase(200, 0, 1'b1);
    wait_idle();

    send_idle_pct = 10; recv_stall_pct = 10;
    set_config(20'd12, 20'd3, 20'd0, 20'h0FFF6, 20'd0);
    t_now = $urandom;
    random_phase(210, 0, 1'b0);
    wait_idle();

    $display("covered %0d sample requests under %0d register settings, %0d streak reports checked",
             items_sent, settings, sb.checked);
    $display("included calms, gaps, time wrap, backwards time and a long receiver hold-off");
    if (sb.errors == 0 && sb.expected_runs.size() == 0) begin
      $display("repeated_value_streak_detector_top verification clean");
    end else begin
      $display("repeated_value_streak_detector_top verification failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout at %0t", $time);
    $display("repeated_value_streak_detector_top verification failed");
    $finish;
  end

endmodule

`default_nettype wire
